>>> src/sjf_pkg.sv
// ----------------------------------------------------------------------------
// sjf_pkg
// Types and constants for the touch-strip jump filter with MIDI CC output.
// ----------------------------------------------------------------------------
package sjf_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CHAN_W       = 3;
    localparam int VAL_W        = 7;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 7;

    localparam logic [VAL_W-1:0] JUMP_LIMIT = 7'd16;
    localparam logic [7:0]       CC_STATUS  = 8'hB0;
    localparam logic [6:0]       CC_BASE    = 7'h10;
    localparam logic [1:0]       FULL_MASK  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_MASK   = 3'd4;

    localparam logic [6:0] RST_FILTER_DELAY = 7'd20;
    localparam logic       RST_SINGLE_MODE  = 1'b1;
    localparam logic [3:0] RST_MIDI_CHANNEL = 4'd0;
    localparam logic       RST_TRAIL_MODE   = 1'b1;
    localparam logic [1:0] RST_TRAIL_MASK   = 2'd3;

    typedef struct packed {
        logic              action;
        logic [CHAN_W-1:0] channel;
        logic [VAL_W-1:0]  sample;
    } t_in_item;

    typedef struct packed {
        logic        send_event;
        logic [7:0]  status_byte;
        logic [6:0]  controller;
        logic [6:0]  cc_value;
        logic [2:0]  dot_strip;
        logic [1:0]  dot_mask;
        logic [5:0]  dot_position;
    } t_out_item;

endpackage

>>> src/softpot_jump_filter_midi_cc.sv
// ----------------------------------------------------------------------------
// softpot_jump_filter_midi_cc
// Per-channel jump filter for touch-strip sensors, emitting MIDI CC and LED
// dot commands for accepted samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per
//   sensor sample or 5 ms tick. Every input beat produces exactly one output
//   beat on (o_out_valid / i_out_ready / o_out_data); send_event marks beats
//   that carry a message, all other fields are zero otherwise.
//   The result is registered at the edge that accepts the input beat.
//   Throughput is one beat per cycle while the receiver takes every beat, set
//   by the single output register, which is refilled in the same cycle it is drained.
//   When the receiver stalls, the output register holds its beat and
//   o_in_ready drops until it is taken.
//   Configuration writes (i_cfg_valid / o_cfg_ready / i_cfg_index /
//   i_cfg_data) are always taken; indexes beyond the register list are
//   ignored. Write only while the block is idle.
//   Synchronous reset clears hold-off counters and last values, loads the
//   register defaults and empties the output register.
// ----------------------------------------------------------------------------
module softpot_jump_filter_midi_cc (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sjf_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sjf_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sjf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sjf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [sjf_pkg::VAL_W-1:0] r_last    [sjf_pkg::NUM_CHANNELS];
    logic [sjf_pkg::VAL_W-1:0] r_holdoff [sjf_pkg::NUM_CHANNELS];
    logic [sjf_pkg::VAL_W-1:0] n_last    [sjf_pkg::NUM_CHANNELS];
    logic [sjf_pkg::VAL_W-1:0] n_holdoff [sjf_pkg::NUM_CHANNELS];

    logic [6:0] r_filter_delay;
    logic       r_single_mode;
    logic [3:0] r_midi_channel;
    logic       r_trail_mode;
    logic [1:0] r_trail_mask;

    logic                r_out_valid;
    sjf_pkg::t_out_item  r_out;
    sjf_pkg::t_out_item  n_out;

    logic                      in_beat;
    logic                      chan_ok;
    logic [sjf_pkg::VAL_W-1:0] prev;
    logic [sjf_pkg::VAL_W-1:0] cur_hold;
    logic [sjf_pkg::VAL_W-1:0] diff;
    logic                      accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_beat     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign chan_ok  = int'(i_in_data.channel) < sjf_pkg::NUM_CHANNELS;
    assign prev     = chan_ok ? r_last[i_in_data.channel] : '0;
    assign cur_hold = chan_ok ? r_holdoff[i_in_data.channel] : '0;
    assign diff     = (i_in_data.sample > prev) ? (i_in_data.sample - prev)
                                                : (prev - i_in_data.sample);
    assign accept   = !i_in_data.action && chan_ok && (i_in_data.sample != '0)
                      && !((diff > sjf_pkg::JUMP_LIMIT) && (cur_hold != '0));

    always_comb begin
        n_out = '0;
        for (int k = 0; k < sjf_pkg::NUM_CHANNELS; k++) begin
            n_last[k]    = r_last[k];
            n_holdoff[k] = r_holdoff[k];
            if (i_in_data.action && (r_holdoff[k] != '0)) begin
                n_holdoff[k] = r_holdoff[k] - 7'd1;
            end
            if (accept && (int'(i_in_data.channel) == k)) begin
                n_holdoff[k] = r_filter_delay;
                n_last[k]    = i_in_data.sample;
            end
        end
        if (accept) begin
            n_out.send_event = 1'b1;
            if (r_single_mode) begin
                n_out.status_byte = sjf_pkg::CC_STATUS | {4'd0, r_midi_channel};
                n_out.controller  = sjf_pkg::CC_BASE + {4'd0, i_in_data.channel};
            end else begin
                n_out.status_byte = sjf_pkg::CC_STATUS | {5'd0, i_in_data.channel};
                n_out.controller  = sjf_pkg::CC_BASE;
            end
            n_out.cc_value     = i_in_data.sample;
            n_out.dot_strip    = i_in_data.channel;
            n_out.dot_mask     = r_trail_mode ? r_trail_mask : sjf_pkg::FULL_MASK;
            n_out.dot_position = i_in_data.sample[6:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_filter_delay <= sjf_pkg::RST_FILTER_DELAY;
            r_single_mode  <= sjf_pkg::RST_SINGLE_MODE;
            r_midi_channel <= sjf_pkg::RST_MIDI_CHANNEL;
            r_trail_mode   <= sjf_pkg::RST_TRAIL_MODE;
            r_trail_mask   <= sjf_pkg::RST_TRAIL_MASK;
            for (int k = 0; k < sjf_pkg::NUM_CHANNELS; k++) begin
                r_last[k]    <= '0;
                r_holdoff[k] <= '0;
            end
        end else begin
            if (in_beat) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
                for (int k = 0; k < sjf_pkg::NUM_CHANNELS; k++) begin
                    r_last[k]    <= n_last[k];
                    r_holdoff[k] <= n_holdoff[k];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sjf_pkg::CFG_FILTER_DELAY: r_filter_delay <= i_cfg_data;
                    sjf_pkg::CFG_SINGLE_MODE:  r_single_mode  <= i_cfg_data[0];
                    sjf_pkg::CFG_MIDI_CHANNEL: r_midi_channel <= i_cfg_data[3:0];
                    sjf_pkg::CFG_TRAIL_MODE:   r_trail_mode   <= i_cfg_data[0];
                    sjf_pkg::CFG_TRAIL_MASK:   r_trail_mask   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
